// File: design/mtf_pkg.sv
// Shared types and codes for the move-to-front search list.
// No dependencies; used by the top level move_to_front_search_list_unit.

package mtf_pkg;

  // Operation codes carried on the func input.
  localparam logic [1:0] FUNC_APPEND = 2'd0;
  localparam logic [1:0] FUNC_SEARCH = 2'd1;
  localparam logic [1:0] FUNC_CLEAR  = 2'd2;

  localparam int unsigned KEY_W = 32;
  localparam int unsigned POS_W = 4;

  // Control sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_SHIFT,
    ST_FRONT,
    ST_DONE
  } state_e;

endpackage

// File: design/mtf_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.

module mtf_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// File: design/move_to_front_search_list_unit.sv
// Move-to-front search list, top level.
// Depends on mtf_pkg and on mtf_ram, which holds the list entries.

// The unit keeps a self-organizing list of up to DEPTH 32-bit keys in a
// single synchronous RAM, plus a count of valid entries in a register, and
// handles one item at a time. Every accepted item produces exactly one result
// transfer. An append writes the key at the tail in the cycle it is accepted
// and then goes straight to the result; when the list already holds DEPTH
// entries it is refused and list_full is set. A clear, and the unused
// function code, also go straight to the result. A search walks the RAM from
// position 0 with one read issued per cycle, each compare using the data of
// the read issued in the cycle before. A hit at position p above 0 then
// shifts the p entries in front of it back by one, again one read and one
// write per cycle through the two RAM ports, and finally writes the key at
// position 0. A finished result sits in an output register, so the next
// input transfer is taken while the result still waits to be collected; only
// the following result waits for that register to drain. position reports
// the old index of the matched key in its low 4 bits.

module move_to_front_search_list_unit #(
  parameter int unsigned DEPTH = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         func_i,
  input  logic signed [31:0] key_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               found_o,
  output logic [3:0]         position_o,
  output logic               list_full_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  mtf_pkg::state_e state_q, state_d;

  logic [CW-1:0]              count_q, count_d;
  logic [CW-1:0]              scan_q, scan_d;
  logic [AW-1:0]              cmp_q, cmp_d;
  logic                       srch_pend_q, srch_pend_d;
  logic [AW-1:0]              sh_q, sh_d;
  logic [AW-1:0]              sh_wr_q, sh_wr_d;
  logic                       sh_rdleft_q, sh_rdleft_d;
  logic                       sh_pend_q, sh_pend_d;
  logic [mtf_pkg::KEY_W-1:0]  key_q, key_d;
  logic                       res_found_q, res_found_d;
  logic [mtf_pkg::POS_W-1:0]  res_pos_q, res_pos_d;
  logic                       res_full_q, res_full_d;

  logic                       out_valid_q, out_valid_d;
  logic                       found_q;
  logic [mtf_pkg::POS_W-1:0]  position_q;
  logic                       list_full_q;

  logic                       ram_we, ram_re;
  logic [AW-1:0]              ram_waddr, ram_raddr;
  logic [mtf_pkg::KEY_W-1:0]  ram_wdata, ram_rdata;

  logic in_xfer, out_free, out_push, issue, hit, is_full;

  assign in_stall_o = (state_q != mtf_pkg::ST_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign is_full    = (count_q == CW'(DEPTH));
  // A read is still to be issued while the scan index is below the count.
  assign issue      = (scan_q < count_q);
  // The compare uses the data of the read issued in the cycle before.
  assign hit        = srch_pend_q && (ram_rdata == key_q);

  mtf_ram #(
    .WIDTH (mtf_pkg::KEY_W),
    .DEPTH (DEPTH)
  ) u_list_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Next-state logic of the sequencer.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      mtf_pkg::ST_IDLE: begin
        if (in_xfer) begin
          if (func_i == mtf_pkg::FUNC_SEARCH && count_q != '0) begin
            state_d = mtf_pkg::ST_SEARCH;
          end else begin
            state_d = mtf_pkg::ST_DONE;
          end
        end
      end
      mtf_pkg::ST_SEARCH: begin
        if (hit) begin
          state_d = (cmp_q == '0) ? mtf_pkg::ST_DONE : mtf_pkg::ST_SHIFT;
        end else if (srch_pend_q && !issue) begin
          state_d = mtf_pkg::ST_DONE;
        end
      end
      mtf_pkg::ST_SHIFT: begin
        if (!sh_rdleft_q) begin
          state_d = mtf_pkg::ST_FRONT;
        end
      end
      mtf_pkg::ST_FRONT: begin
        state_d = mtf_pkg::ST_DONE;
      end
      mtf_pkg::ST_DONE: begin
        if (out_free) begin
          state_d = mtf_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = mtf_pkg::ST_IDLE;
      end
    endcase
  end

  // Datapath, RAM control and result logic per state.
  always_comb begin
    count_d     = count_q;
    scan_d      = scan_q;
    cmp_d       = cmp_q;
    srch_pend_d = srch_pend_q;
    sh_d        = sh_q;
    sh_wr_d     = sh_wr_q;
    sh_rdleft_d = sh_rdleft_q;
    sh_pend_d   = sh_pend_q;
    key_d       = key_q;
    res_found_d = res_found_q;
    res_pos_d   = res_pos_q;
    res_full_d  = res_full_q;
    ram_we      = 1'b0;
    ram_waddr   = '0;
    ram_wdata   = key_q;
    ram_re      = 1'b0;
    ram_raddr   = '0;
    out_push    = 1'b0;

    unique case (state_q)
      mtf_pkg::ST_IDLE: begin
        if (in_xfer) begin
          key_d       = key_i;
          res_found_d = 1'b0;
          res_pos_d   = '0;
          res_full_d  = 1'b0;
          scan_d      = '0;
          srch_pend_d = 1'b0;
          if (func_i == mtf_pkg::FUNC_APPEND) begin
            if (is_full) begin
              res_full_d = 1'b1;
            end else begin
              ram_we    = 1'b1;
              ram_waddr = count_q[AW-1:0];
              ram_wdata = key_i;
              count_d   = count_q + CW'(1);
            end
          end else if (func_i == mtf_pkg::FUNC_CLEAR) begin
            count_d = '0;
          end
        end
      end
      mtf_pkg::ST_SEARCH: begin
        if (issue) begin
          ram_re      = 1'b1;
          ram_raddr   = scan_q[AW-1:0];
          cmp_d       = scan_q[AW-1:0];
          scan_d      = scan_q + CW'(1);
          srch_pend_d = 1'b1;
        end else begin
          srch_pend_d = 1'b0;
        end
        if (hit) begin
          res_found_d = 1'b1;
          res_pos_d   = mtf_pkg::POS_W'(cmp_q);
          sh_d        = cmp_q - AW'(1);
          sh_rdleft_d = 1'b1;
          sh_pend_d   = 1'b0;
        end
      end
      mtf_pkg::ST_SHIFT: begin
        // Entry j-1 is read, then written to j in the next cycle.
        if (sh_pend_q) begin
          ram_we    = 1'b1;
          ram_waddr = sh_wr_q;
          ram_wdata = ram_rdata;
        end
        if (sh_rdleft_q) begin
          ram_re    = 1'b1;
          ram_raddr = sh_q;
          sh_wr_d   = sh_q + AW'(1);
          if (sh_q == '0) begin
            sh_rdleft_d = 1'b0;
          end else begin
            sh_d = sh_q - AW'(1);
          end
        end
        sh_pend_d = sh_rdleft_q;
      end
      mtf_pkg::ST_FRONT: begin
        ram_we    = 1'b1;
        ram_waddr = '0;
        ram_wdata = key_q;
      end
      mtf_pkg::ST_DONE: begin
        out_push = out_free;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_push) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mtf_pkg::ST_IDLE;
      count_q     <= '0;
      srch_pend_q <= 1'b0;
      sh_rdleft_q <= 1'b0;
      sh_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      srch_pend_q <= srch_pend_d;
      sh_rdleft_q <= sh_rdleft_d;
      sh_pend_q   <= sh_pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    scan_q      <= scan_d;
    cmp_q       <= cmp_d;
    sh_q        <= sh_d;
    sh_wr_q     <= sh_wr_d;
    key_q       <= key_d;
    res_found_q <= res_found_d;
    res_pos_q   <= res_pos_d;
    res_full_q  <= res_full_d;
    if (out_push) begin
      found_q     <= res_found_q;
      position_q  <= res_pos_q;
      list_full_q <= res_full_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign found_o     = found_q;
  assign position_o  = position_q;
  assign list_full_o = list_full_q;

  // The entry count never exceeds the list depth.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("entry count above depth");

  // A new result is loaded only when the output register is free.
  a_push_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_push |-> (!out_valid_q || !out_stall_i))
    else $error("result overwrote a pending transfer");

  // The shift never reads and writes the same entry in one cycle.
  a_no_rw_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
    else $error("RAM read and write hit the same entry");

  // A hit and a refused append never appear in the same result.
  a_excl_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(found_o && list_full_o))
    else $error("found and list_full both set");

  // No input transfer is taken while a search or a shift is in progress.
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == mtf_pkg::ST_SEARCH || state_q == mtf_pkg::ST_SHIFT) |-> !in_xfer)
    else $error("input taken during a search");

endmodule
